@@ design/gregorian_date_arithmetic_macros.svh @@
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define GDA_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define GDA_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/gda_pkg.sv @@
package gda_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int YEAR_BITS   = 14;

    // port widths
    localparam int OP_W   = 2;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int OFS_W  = 16;
    localparam int DIFF_W = 24;
    localparam int ST_W   = 2;

    localparam int YEAR_IN_BITS = (YEAR_BITS < YEAR_W) ? YEAR_BITS : YEAR_W;
    localparam int OFS_IN_BITS  = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;

    // working year holds 2^YEAR_BITS itself
    localparam int YW    = YEAR_BITS + 1;
    localparam int QW    = YW - 6;
    localparam int PW    = YW + QW;
    localparam int DN_W  = YEAR_BITS + 9;
    localparam int N_W   = ((DN_W > OFS_IN_BITS) ? DN_W : OFS_IN_BITS) + 2;
    localparam int DF_W  = (DN_W + 1 > DIFF_W) ? DN_W + 1 : DIFF_W;
    localparam int REM_W = 9;
    localparam int KY_W  = YW;
    localparam int EP_W  = DN_W + KY_W;

    // floor(2^YW / 100): quotient estimate low by at most one
    localparam int R100 = (1 << YW) / 100;
    localparam longint YMAX = longint'(1) << YEAR_BITS;
    localparam longint LAST_DN = 365 * YMAX + (YMAX + 3) / 4 - (YMAX + 99) / 100
                                 + (YMAX + 399) / 400;
    // day number to year estimate, 400 / 146097 scaled by 2^DN_W
    localparam longint KY = ((longint'(1) << DN_W) * 400) / 146097;

    localparam logic [OP_W-1:0] OP_VALIDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_SUB      = 2'd2;
    localparam logic [OP_W-1:0] OP_DIFF     = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INV   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_MUL,
        UOP_FIX,
        UOP_YS,
        UOP_DN1,
        UOP_DN2,
        UOP_OFS,
        UOP_EMUL,
        UOP_EST,
        UOP_DEC,
        UOP_BASE_INC,
        UOP_FINAL,
        UOP_WALK,
        UOP_PUSH
    } t_uop;

    typedef enum logic [2:0] {
        K_VALID,
        K_INV,
        K_DIFF,
        K_RANGE,
        K_DATE
    } t_kind;

    typedef struct packed {
        t_uop  uop;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            valid1;
        logic            valid2;
        logic            ys_gt_n;
        logic            out_of_range;
        logic            walk_done;
    } t_stat;

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [REM_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [REM_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                     input logic leap);
        return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_days(m, leap));
    endfunction

endpackage

@@ design/gda_dp.sv @@
module gda_dp (
    input  logic                           i_clk,
    input  gda_pkg::t_cmd                  i_cmd,
    input  logic [gda_pkg::OP_W-1:0]       i_opcode,
    input  logic [gda_pkg::DAY_W-1:0]      i_day,
    input  logic [gda_pkg::MON_W-1:0]      i_month,
    input  logic [gda_pkg::YEAR_W-1:0]     i_year,
    input  logic [gda_pkg::DAY_W-1:0]      i_other_day,
    input  logic [gda_pkg::MON_W-1:0]      i_other_month,
    input  logic [gda_pkg::YEAR_W-1:0]     i_other_year,
    input  logic [gda_pkg::OFS_W-1:0]      i_offset_days,
    output gda_pkg::t_stat                 o_stat,
    output logic [gda_pkg::DAY_W-1:0]      o_res_day,
    output logic [gda_pkg::MON_W-1:0]      o_res_month,
    output logic [gda_pkg::YEAR_W-1:0]     o_res_year,
    output logic signed [gda_pkg::DIFF_W-1:0] o_day_difference,
    output logic [gda_pkg::ST_W-1:0]       o_status
);

    localparam int YW    = gda_pkg::YW;
    localparam int QW    = gda_pkg::QW;
    localparam int PW    = gda_pkg::PW;
    localparam int DN_W  = gda_pkg::DN_W;
    localparam int N_W   = gda_pkg::N_W;
    localparam int DF_W  = gda_pkg::DF_W;
    localparam int REM_W = gda_pkg::REM_W;
    localparam int KY_W  = gda_pkg::KY_W;
    localparam int EP_W  = gda_pkg::EP_W;
    localparam int YB    = gda_pkg::YEAR_BITS;
    localparam int YIB   = gda_pkg::YEAR_IN_BITS;
    localparam int OIB   = gda_pkg::OFS_IN_BITS;
    localparam logic signed [DF_W-1:0] DMAX = DF_W'(8388607);
    localparam logic signed [DF_W-1:0] DMIN = DF_W'(-8388608);

    logic [gda_pkg::OP_W-1:0]  r_op;
    logic [gda_pkg::DAY_W-1:0] r_d1, r_d2;
    logic [gda_pkg::MON_W-1:0] r_m1, r_m2;
    logic [YB-1:0]             r_y1, r_y2;
    logic [OIB-1:0]            r_off;
    logic [YW-1:0]             r_y;
    logic [PW-1:0]             r_prod;
    logic [DN_W-1:0]           r_y365;
    logic [YW-2:0]             r_y4;
    logic [QW-1:0]             r_q;
    logic                      r_leap;
    logic [DN_W-1:0]           r_ys;
    logic [DN_W-1:0]           r_acc;
    logic signed [gda_pkg::DIFF_W-1:0] r_diff;
    logic signed [N_W-1:0]     r_n;
    logic [EP_W-1:0]           r_eprod;
    logic [DN_W-1:0]           r_base;
    logic                      r_bleap;
    logic [REM_W-1:0]          r_rem;
    logic [gda_pkg::MON_W-1:0] r_mm;

    logic [gda_pkg::DAY_W-1:0]  r_res_day;
    logic [gda_pkg::MON_W-1:0]  r_res_month;
    logic [gda_pkg::YEAR_W-1:0] r_res_year;
    logic signed [gda_pkg::DIFF_W-1:0] r_res_diff;
    logic [gda_pkg::ST_W-1:0]   r_res_status;

    logic [YW-1:0]             w_x;
    logic [QW-1:0]             w_q_est;
    logic [YW-1:0]             w_r;
    logic [7:0]                w_r8;
    logic                      w_geq;
    logic [QW-1:0]             w_q_fix;
    logic [6:0]                w_r100;
    logic                      w_leap;
    logic [gda_pkg::DAY_W-1:0] w_d_sel;
    logic [gda_pkg::MON_W-1:0] w_m_sel;
    logic [DN_W-1:0]           w_dn;
    logic signed [DF_W-1:0]    w_dif;
    logic signed [DF_W-1:0]    w_sat;
    logic [KY_W-1:0]           w_est;

    // (y + 99) / 100 by reciprocal; the estimate is fixed up by one compare
    assign w_x     = r_y + YW'(99);
    assign w_q_est = r_prod[PW-1:YW];
    assign w_r     = w_x - YW'(w_q_est) * YW'(100);
    assign w_r8    = w_r[7:0];
    assign w_geq   = w_r8 >= 8'd100;
    assign w_q_fix = w_q_est + QW'(w_geq);
    assign w_r100  = w_geq ? 7'(w_r8 - 8'd100) : w_r8[6:0];
    // y mod 100 == 0 exactly when (y + 99) mod 100 == 99
    assign w_leap  = (r_y[1:0] == 2'b00) && ((w_r100 != 7'd99) || (w_q_fix[1:0] == 2'b00));

    assign w_d_sel = (i_cmd.uop == gda_pkg::UOP_DN2) ? r_d2 : r_d1;
    assign w_m_sel = (i_cmd.uop == gda_pkg::UOP_DN2) ? r_m2 : r_m1;
    assign w_dn    = r_ys + DN_W'(gda_pkg::days_before(w_m_sel)) + DN_W'(w_d_sel) - DN_W'(1)
                     + DN_W'((w_m_sel > 4'd2) && r_leap);

    assign w_dif = $signed(DF_W'(r_acc)) - $signed(DF_W'(w_dn));
    assign w_sat = (w_dif > DMAX) ? DMAX : ((w_dif < DMIN) ? DMIN : w_dif);

    assign w_est = r_eprod[EP_W-1:DN_W];

    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            gda_pkg::UOP_LOAD: begin
                r_op  <= i_opcode;
                r_d1  <= i_day;
                r_m1  <= i_month;
                r_y1  <= YB'(i_year[YIB-1:0]);
                r_d2  <= i_other_day;
                r_m2  <= i_other_month;
                r_y2  <= YB'(i_other_year[YIB-1:0]);
                r_off <= i_offset_days[OIB-1:0];
                r_y   <= YW'(i_year[YIB-1:0]);
            end
            gda_pkg::UOP_MUL: begin
                r_prod <= PW'(w_x) * PW'(gda_pkg::R100);
                r_y365 <= DN_W'(r_y) * DN_W'(365);
                r_y4   <= (YW-1)'((r_y + YW'(3)) >> 2);
            end
            gda_pkg::UOP_FIX: begin
                r_q    <= w_q_fix;
                r_leap <= w_leap;
            end
            gda_pkg::UOP_YS: begin
                r_ys <= r_y365 + DN_W'(r_y4) - DN_W'(r_q)
                        + DN_W'((DN_W'(r_q) + DN_W'(3)) >> 2);
            end
            gda_pkg::UOP_DN1: begin
                r_acc <= w_dn;
                r_y   <= YW'(r_y2);
            end
            gda_pkg::UOP_DN2: begin
                r_diff <= w_sat[gda_pkg::DIFF_W-1:0];
            end
            gda_pkg::UOP_OFS: begin
                if (r_op == gda_pkg::OP_ADD) begin
                    r_n <= N_W'(r_acc) + N_W'(r_off);
                end else begin
                    r_n <= N_W'(r_acc) - N_W'(r_off);
                end
            end
            gda_pkg::UOP_EMUL: begin
                r_eprod <= EP_W'(r_n[DN_W-1:0]) * EP_W'(gda_pkg::KY);
            end
            gda_pkg::UOP_EST: begin
                r_y <= (w_est > YW'(gda_pkg::YMAX)) ? YW'(gda_pkg::YMAX) : w_est;
            end
            gda_pkg::UOP_DEC: begin
                r_y <= r_y - YW'(1);
            end
            gda_pkg::UOP_BASE_INC: begin
                r_base  <= r_ys;
                r_bleap <= r_leap;
                r_y     <= r_y + YW'(1);
            end
            gda_pkg::UOP_FINAL: begin
                r_y   <= r_y - YW'(1);
                r_rem <= REM_W'(r_n[DN_W-1:0] - r_base);
                r_mm  <= 4'd1;
            end
            gda_pkg::UOP_WALK: begin
                r_rem <= r_rem - REM_W'(gda_pkg::month_days(r_mm, r_bleap));
                r_mm  <= r_mm + 4'd1;
            end
            gda_pkg::UOP_PUSH: begin
                r_res_day    <= '0;
                r_res_month  <= '0;
                r_res_year   <= '0;
                r_res_diff   <= '0;
                r_res_status <= gda_pkg::ST_OK;
                case (i_cmd.kind)
                    gda_pkg::K_VALID: begin
                        r_res_day   <= r_d1;
                        r_res_month <= r_m1;
                        r_res_year  <= gda_pkg::YEAR_W'(r_y1);
                    end
                    gda_pkg::K_INV: begin
                        r_res_status <= gda_pkg::ST_INV;
                    end
                    gda_pkg::K_DIFF: begin
                        r_res_diff <= r_diff;
                    end
                    gda_pkg::K_RANGE: begin
                        r_res_status <= gda_pkg::ST_RANGE;
                    end
                    gda_pkg::K_DATE: begin
                        r_res_day   <= gda_pkg::DAY_W'(r_rem + REM_W'(1));
                        r_res_month <= r_mm;
                        r_res_year  <= gda_pkg::YEAR_W'(r_y);
                    end
                    default: begin
                        r_res_status <= gda_pkg::ST_INV;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.valid1       = gda_pkg::date_ok(r_d1, r_m1, r_leap);
        o_stat.valid2       = gda_pkg::date_ok(r_d2, r_m2, r_leap);
        o_stat.ys_gt_n      = r_ys > r_n[DN_W-1:0];
        o_stat.out_of_range = r_n[N_W-1] || ($unsigned(r_n) >= N_W'(gda_pkg::LAST_DN));
        o_stat.walk_done    = (r_mm == 4'd12)
                              || (r_rem < REM_W'(gda_pkg::month_days(r_mm, r_bleap)));
    end

    assign o_res_day        = r_res_day;
    assign o_res_month      = r_res_month;
    assign o_res_year       = r_res_year;
    assign o_day_difference = r_res_diff;
    assign o_status         = r_res_status;

endmodule

@@ design/gda_ctrl.sv @@
module gda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  gda_pkg::t_stat i_stat,
    output gda_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_YS,
        S_DN1,
        S_DN2,
        S_OFS,
        S_RNG,
        S_EST,
        S_CMP,
        S_WALK,
        S_OUT
    } t_state;

    // what the current year-start computation is for
    typedef enum logic [1:0] {
        PH_D1,
        PH_D2,
        PH_DOWN,
        PH_UP
    } t_phase;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    gda_pkg::t_kind r_kind, n_kind;
    logic           r_o_valid, n_o_valid;

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_kind        = r_kind;
        o_cmd.uop     = gda_pkg::UOP_NONE;
        o_cmd.kind    = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.uop = gda_pkg::UOP_LOAD;
                    n_phase   = PH_D1;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.uop = gda_pkg::UOP_MUL;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.uop = gda_pkg::UOP_FIX;
                n_state   = S_YS;
            end
            S_YS: begin
                o_cmd.uop = gda_pkg::UOP_YS;
                case (r_phase)
                    PH_D1:   n_state = S_DN1;
                    PH_D2:   n_state = S_DN2;
                    default: n_state = S_CMP;
                endcase
            end
            S_DN1: begin
                if (!i_stat.valid1) begin
                    n_kind  = gda_pkg::K_INV;
                    n_state = S_OUT;
                end else if (i_stat.op == gda_pkg::OP_VALIDATE) begin
                    n_kind  = gda_pkg::K_VALID;
                    n_state = S_OUT;
                end else if (i_stat.op == gda_pkg::OP_DIFF) begin
                    o_cmd.uop = gda_pkg::UOP_DN1;
                    n_phase   = PH_D2;
                    n_state   = S_MUL;
                end else begin
                    o_cmd.uop = gda_pkg::UOP_DN1;
                    n_state   = S_OFS;
                end
            end
            S_DN2: begin
                if (!i_stat.valid2) begin
                    n_kind = gda_pkg::K_INV;
                end else begin
                    o_cmd.uop = gda_pkg::UOP_DN2;
                    n_kind    = gda_pkg::K_DIFF;
                end
                n_state = S_OUT;
            end
            S_OFS: begin
                o_cmd.uop = gda_pkg::UOP_OFS;
                n_state   = S_RNG;
            end
            S_RNG: begin
                if (i_stat.out_of_range) begin
                    n_kind  = gda_pkg::K_RANGE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.uop = gda_pkg::UOP_EMUL;
                    n_state   = S_EST;
                end
            end
            S_EST: begin
                o_cmd.uop = gda_pkg::UOP_EST;
                n_phase   = PH_DOWN;
                n_state   = S_MUL;
            end
            S_CMP: begin
                // walk down until the year starts at or before n, then up past it
                if (i_stat.ys_gt_n) begin
                    if (r_phase == PH_DOWN) begin
                        o_cmd.uop = gda_pkg::UOP_DEC;
                        n_state   = S_MUL;
                    end else begin
                        o_cmd.uop = gda_pkg::UOP_FINAL;
                        n_state   = S_WALK;
                    end
                end else begin
                    o_cmd.uop = gda_pkg::UOP_BASE_INC;
                    n_phase   = PH_UP;
                    n_state   = S_MUL;
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_kind  = gda_pkg::K_DATE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.uop = gda_pkg::UOP_WALK;
                end
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    o_cmd.uop = gda_pkg::UOP_PUSH;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.uop == gda_pkg::UOP_PUSH) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_D1;
            r_kind    <= gda_pkg::K_INV;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;

endmodule

@@ design/gregorian_date_arithmetic.sv @@
// Validate checks the first date; difference also converts the second date;
// add/subtract makes P year probes of the year-start unit, then walks W months,
// one per cycle, up to 11.
// One word at a time: the next input word is taken the cycle after the result
// enters the output register, which holds it until taken.
// Reset: synchronous, active low; clears the sequencer and output valid only.
`include "gregorian_date_arithmetic_macros.svh"

module gregorian_date_arithmetic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [gda_pkg::OP_W-1:0]          i_opcode,
    input  logic [gda_pkg::DAY_W-1:0]         i_day,
    input  logic [gda_pkg::MON_W-1:0]         i_month,
    input  logic [gda_pkg::YEAR_W-1:0]        i_year,
    input  logic [gda_pkg::DAY_W-1:0]         i_other_day,
    input  logic [gda_pkg::MON_W-1:0]         i_other_month,
    input  logic [gda_pkg::YEAR_W-1:0]        i_other_year,
    input  logic [gda_pkg::OFS_W-1:0]         i_offset_days,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [gda_pkg::DAY_W-1:0]         o_res_day,
    output logic [gda_pkg::MON_W-1:0]         o_res_month,
    output logic [gda_pkg::YEAR_W-1:0]        o_res_year,
    output logic signed [gda_pkg::DIFF_W-1:0] o_day_difference,
    output logic [gda_pkg::ST_W-1:0]          o_status
);

    gda_pkg::t_cmd  w_cmd;
    gda_pkg::t_stat w_stat;

    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gda_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_opcode         (i_opcode),
        .i_day            (i_day),
        .i_month          (i_month),
        .i_year           (i_year),
        .i_other_day      (i_other_day),
        .i_other_month    (i_other_month),
        .i_other_year     (i_other_year),
        .i_offset_days    (i_offset_days),
        .o_stat           (w_stat),
        .o_res_day        (o_res_day),
        .o_res_month      (o_res_month),
        .o_res_year       (o_res_year),
        .o_day_difference (o_day_difference),
        .o_status         (o_status)
    );

    `GDA_ASSERT_IMP(a_push_when_free, w_cmd.uop == gda_pkg::UOP_PUSH, !o_valid || i_ready, "result pushed over a word not yet taken")
    `GDA_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "input still ready right after accept")
    `GDA_ASSERT_IMP(a_fail_fields_zero, o_valid && (o_status != gda_pkg::ST_OK), (o_day_difference == '0) && (o_res_day == '0) && (o_res_month == '0) && (o_res_year == '0), "failed result carries nonzero fields")
    `GDA_ASSERT_IMP(a_date_result_shape, o_valid && (o_status == gda_pkg::ST_OK) && (o_res_month != '0), (o_day_difference == '0) && (o_res_day != '0) && (o_res_month <= 4'd12), "date result malformed")

endmodule
